@@ src/fsl_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame stepper package
// Shared constants, register indexes, mode codes and sequencer states.
// ----------------------------------------------------------------------------
package fsl_pkg;

  localparam int MAX_FRAMES = 256;
  localparam int TIME_BITS  = 24;

  localparam int COUNT_W   = 9;
  localparam int FRAME_W   = 8;
  localparam int PERIOD_W  = COUNT_W + 1;
  localparam int ELAPSED_W = TIME_BITS + 1;
  localparam int QUOT_W    = TIME_BITS + 2;
  localparam int ITER_W    = $clog2(QUOT_W);
  localparam int MODE_W    = 2;
  localparam int REG_IDX_W = 2;
  localparam int CFG_W     = TIME_BITS;
  localparam int IN_DATA_W = ((TIME_BITS + 7) / 8) * 8;
  localparam int OUT_W     = 16;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FRAMES);

  localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_DURATION = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOOP_MODE      = 2'd2;

  localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_RESET   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TIME,
    ST_SETUP,
    ST_DIV_FRAME,
    ST_WRAP,
    ST_FINISH
  } state_t;

endpackage

@@ src/frame_stepper_loop_modes.sv @@
// ----------------------------------------------------------------------------
// Frame stepper with loop, play-once and ping-pong modes
// Steps an animation frame index from elapsed time using one shared divider.
// ----------------------------------------------------------------------------
// Input beats carry an operation flag on s_tuser and the elapsed time on
// s_tdata. Every input beat produces exactly one output beat on m_tdata with
// the frame index, the direction and a finished flag.
// The configuration port writes the frame count, the frame duration and the
// loop mode; it may be written only while the block is idle.
// One restoring divider, producing one quotient bit per cycle, does all the
// arithmetic. The first pass divides the accumulated time by the frame
// duration; the second, used in every mode but play-once when at least one
// frame is stepped, reduces the new position modulo the frame count or twice
// the frame count.
// A reset beat, an advance with no frames or an already finished play-once
// clip skips the divider; other advances make one pass, or two if a frame is
// stepped outside play-once mode. s_tready is low while a beat is in progress.
// The result sits in an output register, so the next input beat is taken
// while a result waits; if the receiver stalls, the following result is held
// in the sequencer until the output register frees.
// The synchronous reset clears the playback state, restores the register
// defaults and empties the output register.
// ----------------------------------------------------------------------------
module frame_stepper_loop_modes (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [fsl_pkg::IN_DATA_W-1:0] s_tdata,  // [23:0] delta_time
  input  logic                         s_tuser,  // [0] op
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [fsl_pkg::OUT_W-1:0]    m_tdata,  // [7:0] frame_index,
                                                 // [8] going_backward,
                                                 // [9] finished
  input  logic                         cfg_we,
  input  logic [fsl_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [fsl_pkg::CFG_W-1:0]    cfg_data
);
  import fsl_pkg::*;

  logic [COUNT_W-1:0]   frame_count;
  logic [TIME_BITS-1:0] frame_duration;
  logic [MODE_W-1:0]    loop_mode;

  state_t state, state_next;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next;
  logic [FRAME_W-1:0]   frame_now, frame_now_next;
  logic                 backward, backward_next;
  logic                 fin, fin_next;
  logic [QUOT_W-1:0]    quot, quot_next;
  logic [TIME_BITS-1:0] rem, rem_next;
  logic [TIME_BITS-1:0] dvsr, dvsr_next;
  logic [ITER_W-1:0]    iter, iter_next;

  logic [FRAME_W-1:0] out_frame;
  logic               out_back;
  logic               out_fin;
  logic               out_load;

  logic [COUNT_W-1:0]   cnt_eff;
  logic [COUNT_W-1:0]   cnt_m1;
  logic [PERIOD_W-1:0]  period;
  logic [TIME_BITS-1:0] dur_eff;
  logic                 is_ping;
  logic                 at_end;
  logic [QUOT_W-1:0]    sum_time;
  logic [ELAPSED_W-1:0] shifted;
  logic [ELAPSED_W-1:0] diff;
  logic                 take;
  logic [COUNT_W-1:0]   room;
  logic [ELAPSED_W-1:0] steps;
  logic                 fold;
  logic [COUNT_W-1:0]   f_adj;
  logic [ELAPSED_W-1:0] n_adj;
  logic [PERIOD_W-1:0]  pos;
  logic [PERIOD_W-1:0]  r_mod;
  logic [PERIOD_W-1:0]  mirror;

  assign cnt_eff = (frame_count > MAX_COUNT) ? MAX_COUNT : frame_count;
  assign cnt_m1  = cnt_eff - COUNT_W'(1);
  assign period  = {cnt_eff, 1'b0};
  assign dur_eff = (frame_duration == '0) ? TIME_BITS'(1) : frame_duration;
  assign is_ping = (loop_mode == MODE_PINGPONG);
  assign at_end  = ({1'b0, frame_now} >= cnt_m1);
  assign sum_time = {1'b0, elapsed} + {2'b0, s_tdata[TIME_BITS-1:0]};

  assign shifted = {rem, quot[QUOT_W-1]};
  assign diff    = shifted - {1'b0, dvsr};
  assign take    = (shifted >= {1'b0, dvsr});

  assign steps  = quot[ELAPSED_W-1:0];
  assign room   = at_end ? '0 : (cnt_m1 - {1'b0, frame_now});
  assign fold   = ({1'b0, frame_now} >= cnt_eff);
  assign f_adj  = fold ? cnt_m1 : {1'b0, frame_now};
  assign n_adj  = steps - (fold ? ELAPSED_W'(1) : '0);
  assign pos    = (fold || backward) ? (period - PERIOD_W'(1) - {1'b0, f_adj})
                                     : {1'b0, f_adj};
  assign r_mod  = rem[PERIOD_W-1:0];
  assign mirror = period - PERIOD_W'(1) - r_mod;

  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_FINISH) && (!m_tvalid || m_tready);
  assign m_tdata  = {{(OUT_W - FRAME_W - 2){1'b0}}, out_fin, out_back, out_frame};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count    <= COUNT_W'(1);
      frame_duration <= TIME_BITS'(1);
      loop_mode      <= MODE_LOOP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_COUNT:    frame_count    <= cfg_data[COUNT_W-1:0];
        REG_FRAME_DURATION: frame_duration <= cfg_data[TIME_BITS-1:0];
        REG_LOOP_MODE:      loop_mode      <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      elapsed   <= '0;
      frame_now <= '0;
      backward  <= 1'b0;
      fin       <= 1'b0;
      iter      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      elapsed   <= elapsed_next;
      frame_now <= frame_now_next;
      backward  <= backward_next;
      fin       <= fin_next;
      iter      <= iter_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    quot <= quot_next;
    rem  <= rem_next;
    dvsr <= dvsr_next;
    if (out_load) begin
      out_frame <= frame_now;
      out_back  <= backward;
      out_fin   <= fin;
    end
  end

  always_comb begin
    state_next     = state;
    elapsed_next   = elapsed;
    frame_now_next = frame_now;
    backward_next  = backward;
    fin_next       = fin;
    quot_next      = quot;
    rem_next       = rem;
    dvsr_next      = dvsr;
    iter_next      = iter;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          fin_next = 1'b0;
          if (s_tuser == OP_RESET) begin
            elapsed_next   = '0;
            frame_now_next = '0;
            backward_next  = 1'b0;
            state_next     = ST_FINISH;
          end else if (cnt_eff == '0) begin
            elapsed_next = '0;
            fin_next     = 1'b1;
            state_next   = ST_FINISH;
          end else if (loop_mode == MODE_ONCE && at_end &&
                       elapsed >= {1'b0, dur_eff}) begin
            elapsed_next = '0;
            fin_next     = 1'b1;
            state_next   = ST_FINISH;
          end else begin
            quot_next  = {1'b0, sum_time[ELAPSED_W-1:0]};
            rem_next   = '0;
            dvsr_next  = dur_eff;
            iter_next  = '0;
            state_next = ST_DIV_TIME;
          end
        end
      end
      ST_DIV_TIME, ST_DIV_FRAME: begin
        rem_next  = take ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
        quot_next = {quot[QUOT_W-2:0], take};
        iter_next = iter + ITER_W'(1);
        if (iter == ITER_W'(QUOT_W - 1)) begin
          state_next = (state == ST_DIV_TIME) ? ST_SETUP : ST_WRAP;
        end
      end
      ST_SETUP: begin
        elapsed_next = {1'b0, rem};
        state_next   = ST_FINISH;
        if (loop_mode == MODE_ONCE) begin
          if (steps > {{(ELAPSED_W - COUNT_W){1'b0}}, room}) begin
            frame_now_next = (cnt_m1 > {1'b0, frame_now}) ? cnt_m1[FRAME_W-1:0]
                                                          : frame_now;
            elapsed_next   = '0;
            fin_next       = 1'b1;
          end else begin
            frame_now_next = frame_now + steps[FRAME_W-1:0];
          end
        end else if (steps != '0) begin
          iter_next  = '0;
          rem_next   = '0;
          state_next = ST_DIV_FRAME;
          if (is_ping) begin
            quot_next = {{(QUOT_W - PERIOD_W){1'b0}}, pos} + {1'b0, n_adj};
            dvsr_next = {{(TIME_BITS - PERIOD_W){1'b0}}, period};
          end else begin
            quot_next = {{(QUOT_W - FRAME_W){1'b0}}, frame_now} + {1'b0, steps};
            dvsr_next = {{(TIME_BITS - COUNT_W){1'b0}}, cnt_eff};
          end
        end
      end
      ST_WRAP: begin
        state_next = ST_FINISH;
        if (is_ping) begin
          if (r_mod < {1'b0, cnt_eff}) begin
            frame_now_next = r_mod[FRAME_W-1:0];
            backward_next  = 1'b0;
          end else begin
            frame_now_next = mirror[FRAME_W-1:0];
            backward_next  = 1'b1;
          end
        end else begin
          frame_now_next = r_mod[FRAME_W-1:0];
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a beat was still in progress");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_TIME || state == ST_DIV_FRAME) |-> (rem < dvsr))
    else $error("divider remainder reached the divisor");

  a_wrap_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRAP) |=> ({1'b0, frame_now} < cnt_eff))
    else $error("wrapped frame index lies outside the clip");

endmodule

@@ dv/frame_stepper_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame stepper result checker
// Watches the configuration port and both stream channels of the frame
// stepper. It keeps its own copy of the registers and of the playback state,
// works out the result of every accepted input beat, and compares each
// result beat, field by field, with the oldest result still due.
// ----------------------------------------------------------------------------
module frame_stepper_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [fsl_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [fsl_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          cfg_we,
  input  logic [fsl_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [fsl_pkg::CFG_W-1:0]     cfg_data,
  output int                            errors,
  output int                            pending,
  output int                            checked,
  output int                            finished_seen,
  output int                            backward_seen
);
  import fsl_pkg::*;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               back;
    logic               fin;
  } frame_beat_t;

  logic [COUNT_W-1:0]   count_q;
  logic [TIME_BITS-1:0] dur_q;
  logic [MODE_W-1:0]    mode_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic [FRAME_W-1:0]   frame_q;
  logic                 back_q;
  frame_beat_t          frames_due[$];

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
    finished_seen = 0;
    backward_seen = 0;
  end

  function automatic frame_beat_t step_playback(input logic op,
                                                input logic [TIME_BITS-1:0] dt);
    frame_beat_t       res;
    int unsigned       cnt;
    int unsigned       dur;
    int unsigned       last;
    int unsigned       room;
    int unsigned       period;
    int unsigned       p;
    longint unsigned   sum;
    longint unsigned   n;
    res.fin = 1'b0;
    if (op == OP_RESET) begin
      elapsed_q = '0;
      frame_q = '0;
      back_q = 1'b0;
    end else begin
      cnt = (count_q > MAX_FRAMES) ? MAX_FRAMES : count_q;
      dur = (dur_q == 0) ? 1 : dur_q;
      last = cnt - 1;
      if (cnt == 0) begin
        elapsed_q = '0;
        res.fin = 1'b1;
      end else if (mode_q == MODE_ONCE && frame_q >= last && elapsed_q >= dur) begin
        elapsed_q = '0;
        res.fin = 1'b1;
      end else begin
        sum = elapsed_q + dt;
        n = sum / dur;
        elapsed_q = ELAPSED_W'(sum % dur);
        if (mode_q == MODE_ONCE) begin
          room = (frame_q >= last) ? 0 : last - frame_q;
          if (n > room) begin
            if (frame_q < last) frame_q = FRAME_W'(last);
            elapsed_q = '0;
            res.fin = 1'b1;
          end else begin
            frame_q = frame_q + FRAME_W'(n);
          end
        end else if (mode_q == MODE_PINGPONG) begin
          if (n > 0) begin
            period = 2 * cnt;
            // A frame left beyond the clip by a smaller count turns round first.
            if (frame_q >= cnt) begin
              frame_q = FRAME_W'(last);
              back_q = 1'b1;
              n = n - 1;
            end
            p = back_q ? period - 1 - frame_q : frame_q;
            p = (p + n % period) % period;
            if (p < cnt) begin
              frame_q = FRAME_W'(p);
              back_q = 1'b0;
            end else begin
              frame_q = FRAME_W'(period - 1 - p);
              back_q = 1'b1;
            end
          end
        end else if (n > 0) begin
          frame_q = FRAME_W'((frame_q + n % cnt) % cnt);
        end
      end
    end
    res.frame = frame_q;
    res.back = back_q;
    return res;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    frame_beat_t due;
    if (rst) begin
      count_q = COUNT_W'(1);
      dur_q = TIME_BITS'(1);
      mode_q = MODE_LOOP;
      elapsed_q = '0;
      frame_q = '0;
      back_q = 1'b0;
      frames_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_COUNT:    count_q = cfg_data[COUNT_W-1:0];
          REG_FRAME_DURATION: dur_q = cfg_data[TIME_BITS-1:0];
          REG_LOOP_MODE:      mode_q = cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (frames_due.size() == 0) begin
          $error("result beat with nothing expected: frame_index %0d",
                 m_tdata[FRAME_W-1:0]);
          errors++;
        end else begin
          due = frames_due.pop_front();
          check_field("frame_index", due.frame, m_tdata[FRAME_W-1:0]);
          check_field("going_backward", due.back, m_tdata[FRAME_W]);
          check_field("finished", due.fin, m_tdata[FRAME_W+1]);
          checked++;
          if (due.fin) finished_seen++;
          if (due.back) backward_seen++;
        end
        check_field("m_tdata padding", 0, m_tdata[OUT_W-1:FRAME_W+2]);
      end
      if (s_tvalid && s_tready) begin
        frames_due.push_back(step_playback(s_tuser, s_tdata[TIME_BITS-1:0]));
      end
    end
    pending <= frames_due.size();
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame stepper regression
// Drives directed and random advance and reset beats through the frame
// stepper under many register settings, with random gaps on the input and
// random stalls on the output, and leaves all checking to the checker.
// ----------------------------------------------------------------------------
module testbench;
  import fsl_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED     = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_UNDEFINED = 2'd3;
  localparam int                   RANDOM_BEATS   = 600;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = OP_ADVANCE;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_FRAME_COUNT;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic quiet = 1'b0;
  int   rx_hold = 0;
  int   errors;
  int   pending;
  int   checked;
  int   finished_seen;
  int   backward_seen;
  int   phases = 0;

  always #5 clk = ~clk;

  frame_stepper_loop_modes u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  frame_stepper_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked),
    .finished_seen(finished_seen),
    .backward_seen(backward_seen)
  );

  // After every result beat the receiver draws how long it stalls the next one.
  always @(posedge clk) begin : rx_side
    int stall;
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold <= 0;
    end else if (m_tvalid && m_tready) begin
      stall = quiet ? 0 : $urandom_range(0, 3);
      rx_hold <= stall;
      m_tready <= (stall == 0);
    end else if (!m_tready) begin
      if (rx_hold <= 1) begin
        m_tready <= 1'b1;
        rx_hold <= 0;
      end else begin
        rx_hold <= rx_hold - 1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("frame_stepper_loop_modes regression: fail");
    $finish;
  end

  task automatic send_beat(input logic op, input logic [TIME_BITS-1:0] dt);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= dt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [COUNT_W-1:0] cnt, input logic [TIME_BITS-1:0] dur,
                            input logic [MODE_W-1:0] mode);
    logic [31:0] junk;
    drain();
    junk = $urandom;
    phases++;
    cfg_we <= 1'b1;
    if (junk[31:30] == 2'd0) begin
      cfg_index <= REG_UNUSED;
      cfg_data <= junk[23:0];
      @(posedge clk);
    end
    cfg_index <= REG_FRAME_COUNT;
    cfg_data <= {junk[23:COUNT_W], cnt};
    @(posedge clk);
    cfg_index <= REG_FRAME_DURATION;
    cfg_data <= dur;
    @(posedge clk);
    cfg_index <= REG_LOOP_MODE;
    cfg_data <= {junk[21:0], mode};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [COUNT_W-1:0]   cnt;
    logic [TIME_BITS-1:0] dur;
    logic [TIME_BITS-1:0] dt;
    logic [MODE_W-1:0]    mode;
    int unsigned          span;
    int                   sent;
    int                   burst;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: one frame, unit duration, loop mode.
    send_beat(OP_ADVANCE, '0);
    send_beat(OP_ADVANCE, '1);
    send_beat(OP_RESET, '1);

    // An empty clip only clears the timer and reports finished.
    set_config('0, 24'd5, MODE_LOOP);
    send_beat(OP_ADVANCE, 24'd5);

    // Oversized count, zero duration and the undefined mode code.
    set_config(9'd300, '0, MODE_UNDEFINED);
    send_beat(OP_ADVANCE, 24'd1000);
    send_beat(OP_ADVANCE, 24'd255);
    send_beat(OP_ADVANCE, '1);

    // Play once: a normal step, running off the end, then a fresh end with time left over.
    set_config(9'd4, 24'd10, MODE_ONCE);
    send_beat(OP_RESET, '0);
    send_beat(OP_ADVANCE, 24'd15);
    send_beat(OP_ADVANCE, 24'd25);
    send_beat(OP_ADVANCE, 24'd3);
    send_beat(OP_RESET, '0);
    send_beat(OP_ADVANCE, 24'd37);
    // A shorter duration leaves more than one frame of time held at the last frame.
    set_config(9'd4, 24'd5, MODE_ONCE);
    send_beat(OP_ADVANCE, '0);

    // Ping-pong turning at both ends.
    set_config(9'd5, 24'd1, MODE_PINGPONG);
    send_beat(OP_RESET, '0);
    send_beat(OP_ADVANCE, 24'd4);
    send_beat(OP_ADVANCE, 24'd1);
    send_beat(OP_ADVANCE, 24'd4);
    send_beat(OP_ADVANCE, 24'd1);
    send_beat(OP_ADVANCE, 24'd23);

    // Frames left beyond a clip that has just been shortened.
    set_config(9'd256, 24'd1, MODE_LOOP);
    send_beat(OP_RESET, '0);
    send_beat(OP_ADVANCE, 24'd200);
    set_config(9'd10, 24'd1, MODE_PINGPONG);
    send_beat(OP_ADVANCE, 24'd3);
    set_config(9'd256, 24'd1, MODE_LOOP);
    send_beat(OP_ADVANCE, 24'd243);
    set_config(9'd7, 24'd1, MODE_ONCE);
    send_beat(OP_ADVANCE, 24'd3);
    set_config(9'd10, 24'd1, MODE_LOOP);
    send_beat(OP_ADVANCE, 24'd1);

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      case ($urandom_range(0, 9))
        0:       cnt = '0;
        1:       cnt = 9'd256;
        2:       cnt = COUNT_W'($urandom_range(257, 511));
        3:       cnt = COUNT_W'($urandom_range(9, 255));
        default: cnt = COUNT_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
        0:       dur = '0;
        1:       dur = '1;
        2:       dur = TIME_BITS'($urandom_range(1, 24'hFFFFFF));
        3, 4:    dur = TIME_BITS'($urandom_range(21, 1000));
        default: dur = TIME_BITS'($urandom_range(1, 20));
      endcase
      mode = MODE_W'($urandom_range(0, 3));
      set_config(cnt, dur, mode);
      quiet <= ($urandom_range(0, 4) == 0);
      span = (dur == 0) ? 3 : 3 * int'(dur);
      if (span > 24'hFFFFFF) span = 24'hFFFFFF;
      burst = $urandom_range(10, 50);
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0:       dt = '0;
          1:       dt = TIME_BITS'($urandom);
          default: dt = TIME_BITS'($urandom_range(0, span));
        endcase
        if ($urandom_range(0, 39) == 0) drain();
        send_beat(($urandom_range(0, 19) == 0) ? OP_RESET : OP_ADVANCE, dt);
        sent++;
      end
    end

    drain();
    repeat (60) @(posedge clk);
    $display("Checked %0d result beats over %0d register settings.", checked, phases);
    $display("%0d results reported finished and %0d were moving backward.",
             finished_seen, backward_seen);
    if (errors == 0) begin
      $display("frame_stepper_loop_modes regression: pass");
    end else begin
      $display("frame_stepper_loop_modes regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/fsl_pkg.sv
src/frame_stepper_loop_modes.sv
dv/frame_stepper_checker.sv
dv/testbench.sv
